// File: design/bmp_pkg.sv
// Shared constants, types and saturating helpers for the Boris momentum push.
package bmp_pkg;

  localparam int DW    = 32;          // external field width
  localparam int FRAC  = 16;          // fraction bits
  localparam int WW    = 64;          // internal word width
  localparam int NIN   = 11;          // fields packed in s_tdata
  localparam int NOUT  = 3;           // fields packed in m_tdata
  localparam int IN_W  = NIN * DW;
  localparam int OUT_W = NOUT * DW;
  localparam int ADDR_W = 4;

  localparam int MUL_LAT   = 4;
  localparam int DIV_STEPS = WW;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  typedef logic signed [WW-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WW-1){1'b0}}};
  localparam word_t FONE     = word_t'(1) <<< FRAC;
  localparam word_t TWO      = word_t'(2) <<< FRAC;
  localparam word_t OUT_MAX  = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam word_t OUT_MIN  = ~OUT_MAX;

  // register indexes
  localparam logic [1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [1:0] REG_MAG_EN    = 2'd1;
  localparam logic [1:0] REG_INV_C     = 2'd2;

  localparam logic [DW-1:0] STEP_RESET  = DW'(1) << FRAC;
  localparam logic [DW-1:0] INV_C_RESET = DW'(1) << FRAC;

  function automatic word_t sext(logic [DW-1:0] x);
    return {{(WW-DW){x[DW-1]}}, x};
  endfunction

  function automatic word_t zext(logic [DW-1:0] x);
    return {{(WW-DW){1'b0}}, x};
  endfunction

  function automatic word_t sadd(word_t a, word_t b);
    logic [WW:0] s;
    s = {a[WW-1], a} + {b[WW-1], b};
    if (s[WW] != s[WW-1]) return s[WW] ? WORD_MIN : WORD_MAX;
    return s[WW-1:0];
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    logic [WW:0] s;
    s = {a[WW-1], a} - {b[WW-1], b};
    if (s[WW] != s[WW-1]) return s[WW] ? WORD_MIN : WORD_MAX;
    return s[WW-1:0];
  endfunction

  function automatic logic [DW-1:0] to_out(word_t v);
    if (v > OUT_MAX) return OUT_MAX[DW-1:0];
    if (v < OUT_MIN) return OUT_MIN[DW-1:0];
    return v[DW-1:0];
  endfunction

endpackage

// File: design/bmp_mul.sv
// Pipelined saturating fixed-point multiplier built from four half-width products.
module bmp_mul (
  input  logic          clk,
  input  logic          en,
  input  bmp_pkg::word_t a,
  input  bmp_pkg::word_t b,
  output bmp_pkg::word_t y
);
  localparam int WW = bmp_pkg::WW;
  localparam int HW = WW / 2;
  localparam int FRAC = bmp_pkg::FRAC;
  localparam int MW = 2 * WW - FRAC;

  logic [WW-1:0]   ua, ub;
  logic            neg1, neg2, neg3;
  logic [WW-1:0]   ll, lh, hl, hh;
  logic [2*WW-1:0] prod;
  logic [MW-1:0]   mag;
  logic            sat;

  assign mag = prod[2*WW-1:FRAC] + MW'(neg3 && (|prod[FRAC-1:0]));
  assign sat = |mag[MW-1:WW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ua   <= a[WW-1] ? -a : a;
      ub   <= b[WW-1] ? -b : b;
      neg1 <= a[WW-1] ^ b[WW-1];
      ll   <= ua[HW-1:0] * ub[HW-1:0];
      lh   <= ua[HW-1:0] * ub[WW-1:HW];
      hl   <= ua[WW-1:HW] * ub[HW-1:0];
      hh   <= ua[WW-1:HW] * ub[WW-1:HW];
      neg2 <= neg1;
      prod <= {{WW{1'b0}}, ll} + {{HW{1'b0}}, lh, {HW{1'b0}}}
            + {{HW{1'b0}}, hl, {HW{1'b0}}} + {hh, {WW{1'b0}}};
      neg3 <= neg2;
      if (sat) begin
        y <= neg3 ? bmp_pkg::WORD_MIN : bmp_pkg::WORD_MAX;
      end else begin
        y <= neg3 ? -bmp_pkg::word_t'(mag[WW-1:0]) : bmp_pkg::word_t'(mag[WW-1:0]);
      end
    end
  end
endmodule

// File: design/bmp_div.sv
// Pipelined restoring fixed-point divider, one quotient bit per stage.
module bmp_div (
  input  logic          clk,
  input  logic          en,
  input  bmp_pkg::word_t a,
  input  bmp_pkg::word_t b,
  output bmp_pkg::word_t y
);
  localparam int WW = bmp_pkg::WW;
  localparam int FRAC = bmp_pkg::FRAC;
  localparam int NS = bmp_pkg::DIV_STEPS;

  typedef struct packed {
    logic [WW-1:0] r;
    logic [WW-1:0] lo;
    logic [WW-1:0] q;
    logic [WW-1:0] ub;
    logic          neg;
    logic          aneg;
    logic          zero_a;
    logic          zero_b;
    logic          sat;
  } dstage_t;

  dstage_t       st [NS+1];
  logic [WW-1:0] ua, ub, hi;

  assign ua = a[WW-1] ? -a : a;
  assign ub = b[WW-1] ? -b : b;
  assign hi = ua >> (WW - FRAC);

  function automatic dstage_t div_step(dstage_t s, int j);
    logic [WW:0] rs;
    logic [WW:0] diff;
    dstage_t     o;
    o    = s;
    rs   = {s.r, s.lo[WW-1-j]};
    diff = rs - {1'b0, s.ub};
    if (rs >= {1'b0, s.ub}) begin
      o.r = diff[WW-1:0];
      o.q[WW-1-j] = 1'b1;
    end else begin
      o.r = rs[WW-1:0];
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].r      <= hi;
      st[0].lo     <= ua << FRAC;
      st[0].q      <= '0;
      st[0].ub     <= ub;
      st[0].neg    <= a[WW-1] ^ b[WW-1];
      st[0].aneg   <= a[WW-1];
      st[0].zero_a <= (ua == '0);
      st[0].zero_b <= (ub == '0);
      st[0].sat    <= (hi >= ub);
      for (int j = 0; j < NS; j++) st[j+1] <= div_step(st[j], j);
      if (st[NS].zero_a) begin
        y <= '0;
      end else if (st[NS].zero_b) begin
        y <= st[NS].aneg ? bmp_pkg::WORD_MIN : bmp_pkg::WORD_MAX;
      end else if (st[NS].sat) begin
        y <= st[NS].neg ? bmp_pkg::WORD_MIN : bmp_pkg::WORD_MAX;
      end else if (st[NS].q[WW-1]) begin
        y <= st[NS].neg ? bmp_pkg::WORD_MIN : bmp_pkg::WORD_MAX;
      end else begin
        y <= st[NS].neg ? -bmp_pkg::word_t'(st[NS].q) : bmp_pkg::word_t'(st[NS].q);
      end
    end
  end
endmodule

// File: design/boris_momentum_push.sv
// Top level of the Boris momentum push: register file, schedule and output buffer.
//
// One particle per transfer on the s_ channel: tdata carries mom, efield, bfield,
// charge and mass; tuser carries half_back. Each particle produces one transfer
// on the m_ channel holding the new momentum. Configuration (step_size,
// magnetic_enable, inv_light_speed) goes through the APB port and must be written
// only while no particle is in flight; the block itself does not enforce this.
//
// The path from the input transfer to m_tvalid runs through two chained 66-stage
// dividers (charge/mass step, then the rotation factor) plus the multiplier
// stages between them. Each multiplier is 4 stages. Throughput: one particle
// per cycle unless the pipe is frozen; every stage of the pipe advances together.
//
// Results land in a two-entry output buffer. While one result waits the pipe
// keeps flowing; only when both entries are full does the whole pipe freeze
// and s_tready drop. Nothing is lost or repeated across a stall.
// Reset (rst, synchronous) restores the registers to their defaults and empties
// the pipe and the output buffer.
module boris_momentum_push (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mom_x, mom_y, mom_z, efield_x, efield_y, efield_z, bfield_x, bfield_y,
  // bfield_z, charge, mass
  input  logic [bmp_pkg::IN_W-1:0]      s_tdata,
  // half_back
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // new_mom_x, new_mom_y, new_mom_z
  output logic [bmp_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmp_pkg::ADDR_W-1:0]    paddr,
  input  logic [bmp_pkg::DW-1:0]        pwdata,
  output logic [bmp_pkg::DW-1:0]        prdata,
  output logic                          pready
);
  localparam int DW = bmp_pkg::DW;
  localparam int ML = bmp_pkg::MUL_LAT;
  localparam int DL = bmp_pkg::DIV_LAT;

  // schedule, in cycles after the input register
  localparam int A = ML + DL;              // qq ready
  localparam int C = A + 3*ML + 3;         // rotation denominator ready
  localparam int B = C + DL;               // rotation factor ready
  localparam int F = B + 3*ML + 3;         // final product ready

  // delay line lengths
  localparam int LP  = 2*ML;
  localparam int LE  = A;
  localparam int LB  = A + ML;
  localparam int LM  = B + 2*ML + 3;
  localparam int LUD = 2*ML;
  localparam int LHE = B + ML + 2 - A;
  localparam int LU  = B + ML - A;
  localparam int LH  = B - A - 2*ML;
  localparam int LW  = B - A - 2*ML - 2;
  localparam int LEO = F - 2*ML - 1;

  // ---------------- configuration ----------------
  logic [DW-1:0] step_size;
  logic          magnetic_enable;
  logic [DW-1:0] inv_light_speed;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= bmp_pkg::STEP_RESET;
      magnetic_enable <= 1'b0;
      inv_light_speed <= bmp_pkg::INV_C_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        bmp_pkg::REG_STEP_SIZE: step_size       <= pwdata;
        bmp_pkg::REG_MAG_EN:    magnetic_enable <= pwdata[0];
        bmp_pkg::REG_INV_C:     inv_light_speed <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bmp_pkg::REG_STEP_SIZE: prdata = step_size;
      bmp_pkg::REG_MAG_EN:    prdata = {{(DW-1){1'b0}}, magnetic_enable};
      bmp_pkg::REG_INV_C:     prdata = inv_light_speed;
      default:                prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic                     en;
  logic                     push;
  logic                     pop;
  logic [1:0]               ocount;
  logic                     wr_ptr, rd_ptr;
  logic [bmp_pkg::OUT_W-1:0] obuf [2];
  logic [bmp_pkg::OUT_W-1:0] push_data;

  assign en       = (ocount != 2'd2);
  assign s_tready = en;
  assign m_tvalid = (ocount != 2'd0);
  assign m_tdata  = obuf[rd_ptr];
  assign pop      = m_tvalid && m_tready;

  // ---------------- input register ----------------
  logic          vld0;
  logic [DW-1:0] p0 [3];
  logic [DW-1:0] e0 [3];
  logic [DW-1:0] b0 [3];
  logic [DW-1:0] q0, m0;
  bmp_pkg::word_t dt0, dt_full;

  assign dt_full = bmp_pkg::zext(step_size);

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (en) vld0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p0[k] <= s_tdata[k*DW +: DW];
        e0[k] <= s_tdata[(3+k)*DW +: DW];
        b0[k] <= s_tdata[(6+k)*DW +: DW];
      end
      q0  <= s_tdata[9*DW +: DW];
      m0  <= s_tdata[10*DW +: DW];
      dt0 <= s_tuser[0] ? -(dt_full >>> 1) : dt_full;
    end
  end

  // ---------------- delay lines ----------------
  logic [DW-1:0]  p_d  [LP][3];
  logic [DW-1:0]  e_d  [LE][3];
  logic [DW-1:0]  b_d  [LB][3];
  logic [DW-1:0]  m_d  [LM];
  bmp_pkg::word_t ud_d [LUD][3];
  bmp_pkg::word_t he_d [LHE][3];
  bmp_pkg::word_t u_d  [LU][3];
  bmp_pkg::word_t h_d  [LH][3];
  bmp_pkg::word_t w_d  [LW][3];
  logic [DW-1:0]  eo_d [LEO][3];
  logic           vld_d [F];

  // datapath values
  bmp_pkg::word_t qd, qq0, qq, hs, f;
  bmp_pkg::word_t udiv [3];
  bmp_pkg::word_t emul [3];
  bmp_pkg::word_t esum [3];
  bmp_pkg::word_t he   [3];
  bmp_pkg::word_t u    [3];
  bmp_pkg::word_t h    [3];
  bmp_pkg::word_t hh   [3];
  bmp_pkg::word_t c1a  [3];
  bmp_pkg::word_t c1b  [3];
  bmp_pkg::word_t t1   [3];
  bmp_pkg::word_t w    [3];
  bmp_pkg::word_t s    [3];
  bmp_pkg::word_t c2a  [3];
  bmp_pkg::word_t c2b  [3];
  bmp_pkg::word_t t2   [3];
  bmp_pkg::word_t y    [3];
  bmp_pkg::word_t z    [3];
  bmp_pkg::word_t fin  [3];
  bmp_pkg::word_t hh0, x1, x2, den;

  assign qq = qq0 >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < F; i++) vld_d[i] <= 1'b0;
    end else if (en) begin
      vld_d[0] <= vld0;
      for (int i = 1; i < F; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d[0]  <= p0;
      e_d[0]  <= e0;
      b_d[0]  <= b0;
      m_d[0]  <= m0;
      ud_d[0] <= udiv;
      he_d[0] <= he;
      u_d[0]  <= u;
      h_d[0]  <= h;
      w_d[0]  <= w;
      for (int k = 0; k < 3; k++) eo_d[0][k] <= bmp_pkg::to_out(esum[k]);
      for (int i = 1; i < LP; i++)  p_d[i]  <= p_d[i-1];
      for (int i = 1; i < LE; i++)  e_d[i]  <= e_d[i-1];
      for (int i = 1; i < LB; i++)  b_d[i]  <= b_d[i-1];
      for (int i = 1; i < LM; i++)  m_d[i]  <= m_d[i-1];
      for (int i = 1; i < LUD; i++) ud_d[i] <= ud_d[i-1];
      for (int i = 1; i < LHE; i++) he_d[i] <= he_d[i-1];
      for (int i = 1; i < LU; i++)  u_d[i]  <= u_d[i-1];
      for (int i = 1; i < LH; i++)  h_d[i]  <= h_d[i-1];
      for (int i = 1; i < LW; i++)  w_d[i]  <= w_d[i-1];
      for (int i = 1; i < LEO; i++) eo_d[i] <= eo_d[i-1];
    end
  end

  // ---------------- saturating adds between the units ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // electric-only update
        esum[k] <= bmp_pkg::sadd(bmp_pkg::sext(p_d[LP-1][k]), emul[k]);
        // half-accelerated velocity
        u[k]    <= bmp_pkg::sadd(ud_d[LUD-1][k], he[k]);
        t1[k]   <= bmp_pkg::ssub(c1a[k], c1b[k]);
        w[k]    <= bmp_pkg::sadd(u_d[2*ML-1][k], t1[k]);
        t2[k]   <= bmp_pkg::ssub(c2a[k], c2b[k]);
        y[k]    <= bmp_pkg::sadd(u_d[LU-1][k], t2[k]);
        z[k]    <= bmp_pkg::sadd(y[k], he_d[LHE-1][k]);
      end
      // 1 + h.h, summed as h1^2 + h2^2 first
      hh0 <= hh[0];
      x1  <= bmp_pkg::sadd(hh[1], hh[2]);
      x2  <= bmp_pkg::sadd(hh0, x1);
      den <= bmp_pkg::sadd(bmp_pkg::FONE, x2);
    end
  end

  // ---------------- arithmetic units ----------------
  bmp_mul u_mul_qd (.clk(clk), .en(en), .a(dt0), .b(bmp_pkg::sext(q0)), .y(qd));
  bmp_div u_div_q  (.clk(clk), .en(en), .a(qd), .b(bmp_pkg::zext(m_d[ML-1])), .y(qq0));
  bmp_mul u_mul_hs (.clk(clk), .en(en), .a(qq), .b(bmp_pkg::zext(inv_light_speed)), .y(hs));
  bmp_div u_div_f  (.clk(clk), .en(en), .a(bmp_pkg::TWO), .b(den), .y(f));

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    bmp_div u_div_u (.clk(clk), .en(en), .a(bmp_pkg::sext(p0[k])),
                     .b(bmp_pkg::zext(m0)), .y(udiv[k]));
    bmp_mul u_mul_e (.clk(clk), .en(en), .a(bmp_pkg::sext(e_d[ML-1][k])), .b(qd),
                     .y(emul[k]));
    bmp_mul u_mul_he (.clk(clk), .en(en), .a(bmp_pkg::sext(e_d[LE-1][k])), .b(qq),
                      .y(he[k]));
    bmp_mul u_mul_h (.clk(clk), .en(en), .a(bmp_pkg::sext(b_d[LB-1][k])), .b(hs),
                     .y(h[k]));
    bmp_mul u_mul_hh (.clk(clk), .en(en), .a(h[k]), .b(h[k]), .y(hh[k]));
    // u x h
    bmp_mul u_mul_c1a (.clk(clk), .en(en), .a(u_d[ML-2][I1]), .b(h[I2]), .y(c1a[k]));
    bmp_mul u_mul_c1b (.clk(clk), .en(en), .a(u_d[ML-2][I2]), .b(h[I1]), .y(c1b[k]));
    bmp_mul u_mul_s (.clk(clk), .en(en), .a(h_d[LH-1][k]), .b(f), .y(s[k]));
    // w x s
    bmp_mul u_mul_c2a (.clk(clk), .en(en), .a(w_d[LW-1][I1]), .b(s[I2]), .y(c2a[k]));
    bmp_mul u_mul_c2b (.clk(clk), .en(en), .a(w_d[LW-1][I2]), .b(s[I1]), .y(c2b[k]));
    bmp_mul u_mul_fin (.clk(clk), .en(en), .a(z[k]), .b(bmp_pkg::zext(m_d[LM-1])),
                       .y(fin[k]));

    assign push_data[k*DW +: DW] = magnetic_enable ? bmp_pkg::to_out(fin[k])
                                                   : eo_d[LEO-1][k];
  end

  // ---------------- output buffer ----------------
  assign push = en && vld_d[F-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      ocount <= ocount + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) obuf[wr_ptr] <= push_data;
  end
endmodule

// File: design/bmp_checker.sv
// Port-level checks for the Boris momentum push, bound to the top level.
module bmp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [bmp_pkg::OUT_W-1:0] m_tdata
);
  // an empty block after reset: nothing to show, room to take
  a_reset_empty: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("result or back-pressure right after reset");

  // input side only blocks while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

  // a blocked input stays blocked until a result is taken
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && !m_tready) |=> !s_tready)
    else $error("input released without an output transfer");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped before transfer");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("stalled result changed");
endmodule

bind boris_momentum_push bmp_checker u_bmp_checker (.*);

// File: test/tb_boris_momentum_push.sv
// Self-checking testbench for the Boris momentum push block.
`timescale 1ns / 1ps

module tb_boris_momentum_push;

  // Wait well past the pipeline latency before register writes.
  localparam int LATENCY    = 167;
  localparam int IDLE_WAIT  = LATENCY + 40;
  localparam int CYCLE_MAX  = 400000;

  typedef struct packed {
    logic        half_back;
    logic [31:0] mass;
    logic [31:0] charge;
    logic [31:0] bz, by, bx;
    logic [31:0] ez, ey, ex;
    logic [31:0] pz, py, px;
  } particle_t;

  typedef struct packed {
    logic [31:0] mz, my, mx;
  } momentum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // mom_x..z, efield_x..z, bfield_x..z, charge, mass
  logic [bmp_pkg::IN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;        // half_back
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bmp_pkg::OUT_W-1:0] m_tdata;       // new_mom_x, new_mom_y, new_mom_z
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bmp_pkg::ADDR_W-1:0] paddr = '0;
  logic [bmp_pkg::DW-1:0] pwdata = '0;
  logic [bmp_pkg::DW-1:0] prdata;
  logic pready;

  boris_momentum_push dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor copy of the register file
  logic [31:0] dt_reg = 32'h0001_0000;
  logic        mag_reg = 1'b0;
  logic [31:0] invc_reg = 32'h0001_0000;

  particle_t pending_particles[$];
  momentum_t expected_momenta[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;   // long stretch with no idling on either side

  // ---------------------------------------------------------------- arithmetic
  function automatic bmp_pkg::word_t fx_mul(bmp_pkg::word_t a, bmp_pkg::word_t b);
    logic signed [127:0] prod;
    prod = 128'(a) * 128'(b);
    prod = prod >>> bmp_pkg::FRAC;               // floor
    if (prod > 128'(bmp_pkg::WORD_MAX)) return bmp_pkg::WORD_MAX;
    if (prod < -128'sd9223372036854775808) return bmp_pkg::WORD_MIN;
    return prod[63:0];
  endfunction

  function automatic bmp_pkg::word_t fx_div(bmp_pkg::word_t a, bmp_pkg::word_t b);
    logic signed [127:0] num, quo;
    if (a == '0) return '0;
    if (b == '0) return a < 0 ? bmp_pkg::WORD_MIN : bmp_pkg::WORD_MAX;
    num = 128'(a) <<< bmp_pkg::FRAC;
    quo = num / 128'(b);                // truncates toward zero
    if (quo > 128'(bmp_pkg::WORD_MAX)) return bmp_pkg::WORD_MAX;
    if (quo < -128'sd9223372036854775808) return bmp_pkg::WORD_MIN;
    return quo[63:0];
  endfunction

  function automatic bmp_pkg::word_t fx_add(bmp_pkg::word_t a, bmp_pkg::word_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(bmp_pkg::WORD_MAX)) return bmp_pkg::WORD_MAX;
    if (s < 65'(bmp_pkg::WORD_MIN)) return bmp_pkg::WORD_MIN;
    return s[63:0];
  endfunction

  function automatic bmp_pkg::word_t fx_sub(bmp_pkg::word_t a, bmp_pkg::word_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(bmp_pkg::WORD_MAX)) return bmp_pkg::WORD_MAX;
    if (s < 65'(bmp_pkg::WORD_MIN)) return bmp_pkg::WORD_MIN;
    return s[63:0];
  endfunction

  function automatic logic [31:0] clamp_out(bmp_pkg::word_t v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // new momentum of one particle under the current register settings
  function automatic momentum_t push_momentum(particle_t it);
    bmp_pkg::word_t p[3], e[3], bf[3], he[3], u[3], h[3], s[3], t[3], w[3], r[3];
    bmp_pkg::word_t q, m, dt, qq, hs, den, f;
    momentum_t o;
    p[0] = bmp_pkg::sext(it.px); p[1] = bmp_pkg::sext(it.py); p[2] = bmp_pkg::sext(it.pz);
    e[0] = bmp_pkg::sext(it.ex); e[1] = bmp_pkg::sext(it.ey); e[2] = bmp_pkg::sext(it.ez);
    bf[0] = bmp_pkg::sext(it.bx); bf[1] = bmp_pkg::sext(it.by);
    bf[2] = bmp_pkg::sext(it.bz);
    q = bmp_pkg::sext(it.charge);
    m = {32'd0, it.mass};
    dt = {32'd0, dt_reg};
    if (it.half_back) dt = -(dt >>> 1);
    if (mag_reg) begin
      qq = fx_div(fx_mul(dt, q), m) >>> 1;
      hs = fx_mul(qq, {32'd0, invc_reg});
      for (int k = 0; k < 3; k++) begin
        he[k] = fx_mul(e[k], qq);
        u[k] = fx_add(fx_div(p[k], m), he[k]);
        h[k] = fx_mul(bf[k], hs);
      end
      den = fx_add(bmp_pkg::FONE, fx_add(fx_mul(h[0], h[0]),
                   fx_add(fx_mul(h[1], h[1]), fx_mul(h[2], h[2]))));
      f = fx_div(bmp_pkg::TWO, den);
      for (int k = 0; k < 3; k++) s[k] = fx_mul(h[k], f);
      t[0] = fx_sub(fx_mul(u[1], h[2]), fx_mul(u[2], h[1]));
      t[1] = fx_sub(fx_mul(u[2], h[0]), fx_mul(u[0], h[2]));
      t[2] = fx_sub(fx_mul(u[0], h[1]), fx_mul(u[1], h[0]));
      for (int k = 0; k < 3; k++) w[k] = fx_add(u[k], t[k]);
      t[0] = fx_sub(fx_mul(w[1], s[2]), fx_mul(w[2], s[1]));
      t[1] = fx_sub(fx_mul(w[2], s[0]), fx_mul(w[0], s[2]));
      t[2] = fx_sub(fx_mul(w[0], s[1]), fx_mul(w[1], s[0]));
      for (int k = 0; k < 3; k++) r[k] = fx_mul(fx_add(fx_add(u[k], t[k]), he[k]), m);
    end else begin
      qq = fx_mul(q, dt);
      for (int k = 0; k < 3; k++) r[k] = fx_add(p[k], fx_mul(e[k], qq));
    end
    o.mx = clamp_out(r[0]); o.my = clamp_out(r[1]); o.mz = clamp_out(r[2]);
    return o;
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      // previous transfer (if any) completed; predict it now
      if (s_tvalid) expected_momenta.push_back(push_momentum(particle_t'({s_tuser, s_tdata})));
      if (pending_particles.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        particle_t nx;
        nx = pending_particles.pop_front();
        s_tdata <= nx[bmp_pkg::IN_W-1:0];
        s_tuser <= nx.half_back;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        momentum_t got, want;
        got = m_tdata;
        if (expected_momenta.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_momenta.pop_front();
          if (got.mx !== want.mx) begin
            $display("%0t: new_mom_x expected %h actual %h", $time, want.mx, got.mx);
            errors++;
          end
          if (got.my !== want.my) begin
            $display("%0t: new_mom_y expected %h actual %h", $time, want.my, got.my);
            errors++;
          end
          if (got.mz !== want.mz) begin
            $display("%0t: new_mom_z expected %h actual %h", $time, want.mz, got.mz);
            errors++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequencing
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bmp_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bmp_pkg::REG_STEP_SIZE: dt_reg = val;
      bmp_pkg::REG_MAG_EN:    mag_reg = val[0];
      bmp_pkg::REG_INV_C:     invc_reg = val;
      default: ;
    endcase
  endtask

  // block is drained: nothing queued, nothing on the bus, nothing expected
  task automatic drain();
    while (pending_particles.size() > 0 || s_tvalid || expected_momenta.size() > 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;   // +/-2.0
    endcase
  endfunction

  function automatic particle_t rnd_particle(bit wild);
    particle_t it;
    it = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom, $urandom};
    if (!wild) begin
      it.px = rnd_field(); it.py = rnd_field(); it.pz = rnd_field();
      it.ex = rnd_field(); it.ey = rnd_field(); it.ez = rnd_field();
      it.bx = rnd_field(); it.by = rnd_field(); it.bz = rnd_field();
      it.charge = rnd_field();
      it.mass = $urandom_range(3) == 0 ? $urandom : 32'h0000_8000 + $urandom_range(32'h0003_0000);
    end
    if (it.mass == 0) it.mass = 1;
    it.half_back = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic queue_directed();
    particle_t it;
    // zero inputs, unit mass
    it = '0; it.mass = 32'h0001_0000;
    pending_particles.push_back(it);
    // all fields at positive max, mass max
    it = {1'b0, 32'hffff_ffff, {10{32'h7fff_ffff}}};
    pending_particles.push_back(it);
    // all fields at negative min, smallest mass, half step
    it = {1'b1, 32'h0000_0001, {10{32'h8000_0000}}};
    pending_particles.push_back(it);
    // ones in every field
    it = {1'b1, 32'hffff_ffff, {10{32'hffff_ffff}}};
    pending_particles.push_back(it);
    // unit field/charge, moderate momentum
    it = '0; it.mass = 32'h0001_0000; it.charge = 32'h0001_0000;
    it.ex = 32'h0001_0000; it.bz = 32'h0001_0000; it.px = 32'h0002_0000;
    pending_particles.push_back(it);
    it.half_back = 1'b1;
    pending_particles.push_back(it);
    // negative charge, mixed fields
    it.charge = 32'hffff_0000; it.by = 32'hfffe_0000; it.ez = 32'h0000_8000;
    pending_particles.push_back(it);
    // overflow of the rotation intermediates
    it = {1'b0, 32'h0000_0001, 32'h7fff_ffff, {3{32'h7fff_ffff}}, {3{32'h4000_0000}},
          {3{32'h0100_0000}}};
    pending_particles.push_back(it);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: electric-only update
    queue_directed();
    drain();

    apb_write(bmp_pkg::REG_MAG_EN, 32'd1);
    queue_directed();
    drain();

    // extremes of step_size and inv_light_speed
    apb_write(bmp_pkg::REG_STEP_SIZE, 32'hffff_ffff);
    apb_write(bmp_pkg::REG_INV_C, 32'd0);
    queue_directed();
    drain();

    apb_write(bmp_pkg::REG_STEP_SIZE, 32'd0);
    apb_write(bmp_pkg::REG_INV_C, 32'hffff_ffff);
    queue_directed();
    drain();

    // random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(bmp_pkg::REG_MAG_EN, ph % 4 != 3 ? {$urandom} : 32'd0);
      apb_write(bmp_pkg::REG_STEP_SIZE, ph == 7 ? 32'hffff_ffff :
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0002_0000));
      apb_write(bmp_pkg::REG_INV_C, ph == 6 ? 32'hffff_ffff :
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0002_0000));
      calm = (ph == 2);
      for (int n = 0; n < 175; n++)
        pending_particles.push_back(rnd_particle($urandom_range(9) == 0));
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
